// ----- rtl/c_escape_sequence_decoder_unit_macros.svh -----
// Assertion macros shared by the escape decoder checker.
`ifndef C_ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CESD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CESD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/cesd_pkg.sv -----
// Types, character codes and lookup functions of the escape decoder.
package cesd_pkg;

  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX0 = 3'd2,
    MODE_HEX1 = 3'd3,
    MODE_OCT1 = 3'd4,
    MODE_OCT2 = 3'd5
  } mode_e;

  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;

  typedef struct packed {
    logic       last_in_run;
    logic       string_end;
    logic       byte_valid;
    logic [7:0] out_byte;
  } result_t;

  // Results of one input character: one or two slots.
  typedef struct packed {
    result_t r1;
    result_t r0;
    logic    two;
  } record_t;

  // Control byte of a single-letter escape; bit 8 flags a hit.
  function automatic logic [8:0] esc_ctrl(input logic [7:0] c);
    logic [8:0] r;
    r = 9'd0;
    case (c)
      8'h61: r = {1'b1, 8'd7};   // a
      8'h62: r = {1'b1, 8'd8};   // b
      8'h66: r = {1'b1, 8'd12};  // f
      8'h6E: r = {1'b1, 8'd10};  // n
      8'h72: r = {1'b1, 8'd13};  // r
      8'h74: r = {1'b1, 8'd9};   // t
      8'h76: r = {1'b1, 8'd11};  // v
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Hex digit value of either case; bit 4 flags a digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

endpackage

// ----- rtl/c_escape_sequence_decoder_unit.sv -----
// A request's first result passes the record queue and then the back end's output register.
// Throughput: one request per cycle while each yields one result and the output is not stalled;
//   the output port sends one result per cycle unless stalled, so a request yielding two results sends them in turn.
// The QueueDepth-entry record queue lets the front end keep accepting while the output stalls.
// Reset (rst_ni low, asynchronous) returns the decoder to plain text, empties the queue
//   and drops any result held at the output.
module c_escape_sequence_decoder_unit
  import cesd_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input character stream.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // end_of_string
  // Decoded byte stream.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser_o,   // [0] byte_valid, [1] string_end
  output logic       m_axis_tlast_o    // last_in_run
);

  logic    q_push, q_full, q_pop, q_valid;
  record_t q_wdata, q_rdata;
  result_t res;

  // Front end: mode machine, up to two results built per request.
  cesd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_ready_o      (s_axis_tready_o),
    .char_in_i       (s_axis_tdata_i),
    .end_of_string_i (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  // Records wait here, so a stalled output does not stop the front end at once.
  cesd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  // Back end: hold one record in a register and send its slots in order.
  cesd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = res.out_byte;
  assign m_axis_tuser_o = {res.string_end, res.byte_valid};
  assign m_axis_tlast_o = res.last_in_run;

endmodule

// ----- rtl/cesd_front.sv -----
// Front end: accept characters, run the escape mode machine, build result records.
module cesd_front
  import cesd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       end_of_string_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output record_t    q_data_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] pend_q, pend_d;

  logic       accept;
  logic [4:0] hx;
  logic [8:0] ctrl;
  logic       plain;
  logic       pre_v, plain_v, fin_v, fin_bv;
  logic [7:0] pre_b, plain_b, fin_b;
  logic [1:0] cnt;
  result_t    r0, r1;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign hx         = hex_val(char_in_i);
  assign ctrl       = esc_ctrl(char_in_i);

  // Next mode and the candidate results: pending flush, plain char, end flush.
  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    plain   = 1'b0;
    pre_v   = 1'b0;
    pre_b   = pend_q;
    plain_v = 1'b0;
    plain_b = char_in_i;
    fin_v   = 1'b0;
    fin_bv  = 1'b1;
    fin_b   = 8'd0;
    unique case (mode_q)
      MODE_ESC: begin
        if (ctrl[8]) begin
          pre_v  = 1'b1;
          pre_b  = ctrl[7:0];
          mode_d = MODE_TEXT;
        end else if (char_in_i == CHAR_X) begin
          mode_d = MODE_HEX0;
        end else if (is_oct(char_in_i)) begin
          pend_d = {5'd0, char_in_i[2:0]};
          mode_d = MODE_OCT1;
        end else begin
          plain = 1'b1;
        end
      end
      MODE_HEX0: begin
        if (hx[4]) begin
          pend_d = {4'd0, hx[3:0]};
          mode_d = MODE_HEX1;
        end else begin
          plain = 1'b1;
        end
      end
      MODE_HEX1: begin
        pre_v = 1'b1;
        if (hx[4]) begin
          pre_b  = {pend_q[3:0], hx[3:0]};
          mode_d = MODE_TEXT;
        end else begin
          plain = 1'b1;
        end
      end
      MODE_OCT1: begin
        if (is_oct(char_in_i)) begin
          pend_d = {pend_q[4:0], char_in_i[2:0]};
          mode_d = MODE_OCT2;
        end else begin
          pre_v = 1'b1;
          plain = 1'b1;
        end
      end
      MODE_OCT2: begin
        pre_v = 1'b1;
        if (is_oct(char_in_i)) begin
          pre_b  = {pend_q[4:0], char_in_i[2:0]};
          mode_d = MODE_TEXT;
        end else begin
          plain = 1'b1;
        end
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      if (char_in_i == CHAR_BSLASH) begin
        mode_d = MODE_ESC;
      end else begin
        mode_d  = MODE_TEXT;
        plain_v = 1'b1;
      end
    end

    // End of string: flush a held value, or send an empty marker if nothing else went out.
    if (end_of_string_i) begin
      if (mode_d == MODE_HEX1 || mode_d == MODE_OCT1 || mode_d == MODE_OCT2) begin
        fin_v = 1'b1;
        fin_b = pend_d;
      end else if (!pre_v && !plain_v) begin
        fin_v  = 1'b1;
        fin_bv = 1'b0;
      end
      mode_d = MODE_TEXT;
      pend_d = 8'd0;
    end
  end

  // Pack the candidates in order into the two slots and mark the final one.
  always_comb begin
    r0  = '0;
    r1  = '0;
    cnt = 2'(pre_v) + 2'(plain_v) + 2'(fin_v);
    if (pre_v) begin
      r0.out_byte   = pre_b;
      r0.byte_valid = 1'b1;
      r1.out_byte   = plain_v ? plain_b : fin_b;
      r1.byte_valid = plain_v ? 1'b1 : fin_bv;
    end else if (plain_v) begin
      r0.out_byte   = plain_b;
      r0.byte_valid = 1'b1;
      r1.out_byte   = fin_b;
      r1.byte_valid = fin_bv;
    end else begin
      r0.out_byte   = fin_b;
      r0.byte_valid = fin_bv;
    end
    if (cnt == 2'd2) begin
      r1.last_in_run = 1'b1;
      r1.string_end  = end_of_string_i;
    end else begin
      r0.last_in_run = 1'b1;
      r0.string_end  = end_of_string_i;
    end
  end

  assign q_push_o = accept && (cnt != 2'd0);
  assign q_data_o = '{r1: r1, r0: r0, two: (cnt == 2'd2)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TEXT;
      pend_q <= 8'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ----- rtl/cesd_fifo.sv -----
// Short record queue between front end and back end.
module cesd_fifo
  import cesd_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  record_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output record_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  record_t             mem_q [Depth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

// ----- rtl/cesd_back.sv -----
// Back end: take records from the queue and send their results one per cycle unless stalled.
module cesd_back
  import cesd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  record_t q_data_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  record_t rec_q;
  logic    have_q, have_d;
  logic    sel_q, sel_d;
  logic    fire, slot_done;

  assign out_valid_o = have_q;
  assign out_o       = sel_q ? rec_q.r1 : rec_q.r0;
  assign fire        = have_q && out_ready_i;
  assign slot_done   = fire && (sel_q || !rec_q.two);
  assign q_pop_o     = q_valid_i && (!have_q || slot_done);

  always_comb begin
    have_d = have_q;
    sel_d  = sel_q;
    if (q_pop_o) begin
      have_d = 1'b1;
      sel_d  = 1'b0;
    end else if (slot_done) begin
      have_d = 1'b0;
      sel_d  = 1'b0;
    end else if (fire) begin
      sel_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      sel_q  <= 1'b0;
    end else begin
      have_q <= have_d;
      sel_q  <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) rec_q <= q_data_i;
  end

endmodule

// ----- rtl/c_escape_sequence_decoder_unit_checker.sv -----
// Port-level checker for the escape decoder and its bind.
`include "c_escape_sequence_decoder_unit_macros.svh"

module cesd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [1:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // Hold a stalled result unchanged.
  `CESD_ASSERT(a_out_hold, (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o)), "stalled result changed")

  // End of string always closes the request's run.
  `CESD_ASSERT(a_end_is_last, (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> m_axis_tlast_o, "string end without last")

  // An empty result is only the end-of-string marker, with a zero byte.
  `CESD_ASSERT(a_empty_marker, (m_axis_tvalid_o && !m_axis_tuser_o[0]) |-> (m_axis_tuser_o[1] && m_axis_tlast_o && m_axis_tdata_o == 8'd0), "bad empty result")

  // Nothing leaves right after reset.
  `CESD_ASSERT_ALWAYS(a_reset_quiet, $past(!rst_ni) |-> !m_axis_tvalid_o, "output valid right after reset")

endmodule

bind c_escape_sequence_decoder_unit cesd_checker u_cesd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ----- test/cesd_decode_monitor.sv -----
`timescale 1ns / 1ps
// Watches both streams of the escape decoder, predicts its bytes, and compares them.
module cesd_decode_monitor
  import cesd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  input  logic       s_axis_tready_i,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tlast_i,
  input  logic       m_axis_tvalid_i,
  input  logic       m_axis_tready_i,
  input  logic [7:0] m_axis_tdata_i,
  input  logic [1:0] m_axis_tuser_i,
  input  logic       m_axis_tlast_i,
  output int         errors_o,
  output int         waiting_o
);

  mode_e      dec_mode;
  logic [7:0] held_val;
  result_t    step_res [2];
  int         step_n;
  result_t    expected_bytes_q [$];

  function automatic int hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic bit octal(input logic [7:0] c);
    return c >= CHAR_ZERO && c <= CHAR_SEVEN;
  endfunction

  function void put_byte(input logic [7:0] b, input logic v);
    step_res[step_n] = '{last_in_run: 1'b0, string_end: 1'b0, byte_valid: v, out_byte: b};
    step_n++;
  endfunction

  function void as_text(input logic [7:0] c);
    if (c == CHAR_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_TEXT;
      put_byte(c, 1'b1);
    end
  endfunction

  function void decode_char(input logic [7:0] c, input logic fin);
    int h;
    h = hex_of(c);
    step_n = 0;
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_TEXT;
        case (c)
          "a": put_byte(8'd7, 1'b1);
          "b": put_byte(8'd8, 1'b1);
          "f": put_byte(8'd12, 1'b1);
          "n": put_byte(8'd10, 1'b1);
          "r": put_byte(8'd13, 1'b1);
          "t": put_byte(8'd9, 1'b1);
          "v": put_byte(8'd11, 1'b1);
          CHAR_X: dec_mode = MODE_HEX0;
          default: begin
            if (octal(c)) begin
              held_val = c - CHAR_ZERO;
              dec_mode = MODE_OCT1;
            end else begin
              as_text(c);
            end
          end
        endcase
      end
      MODE_HEX0: begin
        if (h >= 0) begin
          held_val = 8'(h);
          dec_mode = MODE_HEX1;
        end else begin
          as_text(c);
        end
      end
      MODE_HEX1: begin
        if (h >= 0) begin
          put_byte({held_val[3:0], 4'(h)}, 1'b1);
          dec_mode = MODE_TEXT;
        end else begin
          put_byte(held_val, 1'b1);
          as_text(c);
        end
      end
      MODE_OCT1, MODE_OCT2: begin
        if (!octal(c)) begin
          put_byte(held_val, 1'b1);
          as_text(c);
        end else if (dec_mode == MODE_OCT1) begin
          held_val = 8'((held_val << 3) | (c - CHAR_ZERO));
          dec_mode = MODE_OCT2;
        end else begin
          put_byte(8'((held_val << 3) | (c - CHAR_ZERO)), 1'b1);
          dec_mode = MODE_TEXT;
        end
      end
      default: as_text(c);
    endcase

    if (fin) begin
      // flush a half-built value; a bare backslash or backslash-x gives only the empty marker
      if (dec_mode == MODE_HEX1 || dec_mode == MODE_OCT1 || dec_mode == MODE_OCT2)
        put_byte(held_val, 1'b1);
      if (step_n == 0) put_byte(8'd0, 1'b0);
      dec_mode = MODE_TEXT;
      held_val = 8'd0;
      step_res[step_n-1].string_end = 1'b1;
    end
    if (step_n > 0) step_res[step_n-1].last_in_run = 1'b1;
    for (int i = 0; i < step_n; i++) expected_bytes_q.push_back(step_res[i]);
  endfunction

  always @(posedge clk_i) begin
    result_t got, want;
    if (!rst_ni) begin
      dec_mode = MODE_TEXT;
      held_val = 8'd0;
      errors_o = 0;
      waiting_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) decode_char(s_axis_tdata_i, s_axis_tlast_i);
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{last_in_run: m_axis_tlast_i, string_end: m_axis_tuser_i[1],
                byte_valid: m_axis_tuser_i[0], out_byte: m_axis_tdata_i};
        if (expected_bytes_q.size() == 0) begin
          $display("%0t: unexpected result: byte %h valid %b end %b last %b", $time,
                   got.out_byte, got.byte_valid, got.string_end, got.last_in_run);
          errors_o++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch: expected byte %h valid %b end %b last %b, got byte %h valid %b end %b last %b",
                     $time, want.out_byte, want.byte_valid, want.string_end, want.last_in_run,
                     got.out_byte, got.byte_valid, got.string_end, got.last_in_run);
            errors_o++;
          end
        end
      end
      waiting_o = expected_bytes_q.size();
    end
  end

endmodule

// ----- test/tb_c_escape_sequence_decoder_unit.sv -----
`timescale 1ns / 1ps
// Top of the escape decoder testbench: clock, reset, character stimulus and verdict.
module tb_c_escape_sequence_decoder_unit
  import cesd_pkg::*;
();

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;   // [7:0] char_in
  logic       s_axis_tlast = 1'b0;   // end_of_string
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic [1:0] m_axis_tuser;          // [0] byte_valid, [1] string_end
  logic       m_axis_tlast;          // last_in_run

  int errors;
  int waiting;
  int chars_sent = 0;
  bit no_gaps = 1'b0;   // high during the stretch where neither side idles

  string hex_digits = "0123456789abcdefABCDEF";
  string ctrl_letters = "abfnrtv";

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  c_escape_sequence_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

  cesd_decode_monitor mon (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .m_axis_tlast_i  (m_axis_tlast),
    .errors_o        (errors),
    .waiting_o       (waiting)
  );

  // Stall the decoded stream at random, with a chance of 28 in 100, except in the quiet stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= no_gaps ? 1'b1 : ($urandom_range(99) >= 28);
  end

  // Send one request; idle at random first, then hold it until the decoder takes it.
  task automatic send_char(input logic [7:0] c, input logic fin);
    while (!no_gaps && $urandom_range(99) < 28) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
  endtask

  // Send a whole text; flag the last character as the end of string when asked.
  task automatic send_text(input string txt, input logic fin);
    for (int i = 0; i < txt.len(); i++) send_char(txt[i], fin && (i == txt.len() - 1));
  endtask

  // Drop valid and wait until every predicted byte has come out.
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
    @(posedge clk_i);
  endtask

  // Build one string from random escape pieces, then send it with the end flag on its tail.
  task automatic send_random_string();
    logic [7:0] str_q [$];
    int pieces, n;
    pieces = $urandom_range(1, 8);
    for (int p = 0; p < pieces; p++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: str_q.push_back(8'($urandom_range(1, 255)));
        3: begin
          str_q.push_back(CHAR_BSLASH);
          str_q.push_back(ctrl_letters[$urandom_range(0, 6)]);
        end
        4, 5: begin
          str_q.push_back(CHAR_BSLASH);
          str_q.push_back(CHAR_X);
          n = $urandom_range(0, 3);
          for (int i = 0; i < n; i++) str_q.push_back(hex_digits[$urandom_range(0, 21)]);
        end
        6, 7: begin
          // octal run, sometimes with an eight or nine mixed in
          str_q.push_back(CHAR_BSLASH);
          n = $urandom_range(1, 4);
          for (int i = 0; i < n; i++) str_q.push_back(8'("0" + $urandom_range(0, 9)));
        end
        default: begin
          str_q.push_back(CHAR_BSLASH);
          str_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
    // leave a dangling escape on the tail now and then
    case ($urandom_range(0, 9))
      0: str_q.push_back(CHAR_BSLASH);
      1: begin
        str_q.push_back(CHAR_BSLASH);
        str_q.push_back(CHAR_X);
      end
      default: ;
    endcase
    for (int i = 0; i < str_q.size(); i++) send_char(str_q[i], i == str_q.size() - 1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // control letters, two-digit hex, backslash-x without digit, eight after
    // backslash, three-digit octal overflowing 8 bits, then a lone trailing backslash
    send_text("\\a\\b\\f\\n\\r\\t\\v\\x4F\\x\\8\\777", 1'b0);
    send_char(CHAR_BSLASH, 1'b1);
    drain_output();

    while (chars_sent < 590) begin
      no_gaps <= (chars_sent >= 250 && chars_sent < 400);
      if ($urandom_range(0, 7) == 0) drain_output();
      send_random_string();
    end
    s_axis_tvalid <= 1'b0;
    no_gaps <= 1'b0;

    do @(negedge clk_i); while (waiting != 0);
    repeat (20) @(negedge clk_i);
    if (errors == 0 && waiting == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/cesd_pkg.sv
rtl/cesd_front.sv
rtl/cesd_fifo.sv
rtl/cesd_back.sv
rtl/c_escape_sequence_decoder_unit.sv
rtl/c_escape_sequence_decoder_unit_checker.sv
test/cesd_decode_monitor.sv
test/tb_c_escape_sequence_decoder_unit.sv
